[src/assert_macros.svh]
// Assertion macros used by the top level of the stream statistics block.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// cond must never hold
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

[src/smrs_pkg.sv]
// Shared widths, constants and job/result types for the stream statistics block.
// No dependencies.
`default_nettype none

package smrs_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = SAMPLE_W + CNT_W - 1;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SQ_W       = PROD_W + CNT_W - 2;
    localparam int DIV_W      = SQ_W;
    localparam int SQRT_IN_W  = ((SQ_W + 1) / 2) * 2;
    localparam int ROOT_W     = SQRT_IN_W / 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int LVL_W      = $clog2(Q_DEPTH + 1);
    localparam int RES_BITS   = 3 * SAMPLE_W + CNT_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // one closed run, handed from the accumulator to the back end
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        cnt;
        logic                    ovf;
    } t_job;

    // one statistics result
    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] rms;
        logic [SAMPLE_W-1:0] stdev;
        logic [CNT_W-1:0]    cnt;
        logic                ovf;
    } t_result;

endpackage

`default_nettype wire

[src/stream_mean_rms_stdev.sv]
// Top level of the stream mean / RMS / standard deviation block.
// Depends on smrs_pkg, smrs_front, smrs_queue, smrs_back and assert_macros.svh.
//
// Sample beats are taken one per clock while tready is high, a beat with
// tlast closing the run; each closed run yields one result beat with mean,
// RMS, standard deviation, sample count and a capacity-overflow flag. The
// accumulator takes a new beat every cycle as long as the two-entry run
// queue has room. The close-out arithmetic for one run, from the queue pop
// to the result beat, uses the shared divider (59 steps, one quotient bit
// per cycle, plus start and hand-back, used for the mean and the mean
// square), the shared square root unit (30 steps, two radicand bits per
// cycle, plus start and hand-back, used for RMS and deviation) and the
// multiply, subtract and output steps. A closing beat passes through the
// accumulator's square stage and the queue before the back end takes it.
// An empty run skips the arithmetic and gives a result of all zeros.
// Runs shorter than the close-out arithmetic are absorbed by the queue,
// after which tready drops until the back end has caught up.
`default_nettype none
`include "assert_macros.svh"

module stream_mean_rms_stdev
    import smrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,  // [23:0] sample
    input  wire logic                  s_axis_tuser,  // [0] has_sample
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [23:0] mean_out, [47:24] rms_out, [71:48] stdev_out,
    // [84:72] sample_count, [87:85] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tuser   // [0] overflowed
);

    logic             push;
    t_job             push_job;
    logic             pop;
    logic             q_valid;
    t_job             q_job;
    logic [LVL_W-1:0] q_level;
    t_result          result;

    smrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata),
        .i_has_sample (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_level      (q_level),
        .o_push       (push),
        .o_job        (push_job)
    );

    smrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_level (q_level)
    );

    smrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_result  (result)
    );

    // result beat packing
    assign m_axis_tdata = {(OUT_DATA_W-RES_BITS)'(0), result.cnt, result.stdev,
                           result.rms, result.mean};
    assign m_axis_tuser = result.ovf;

    // checks
    `ASSERT_NEVER(a_queue_overfill, i_clk, i_rst_n,
                  (q_level == LVL_W'(Q_DEPTH)) && push && !pop)
    `ASSERT_IMPLIES(a_pop_needs_entry, i_clk, i_rst_n, pop, q_valid)
    `ASSERT_IMPLIES(a_empty_run_zero, i_clk, i_rst_n,
                    m_axis_tvalid && (result.cnt == '0),
                    (result.mean == '0) && (result.rms == '0) &&
                    (result.stdev == '0) && !result.ovf)
    `ASSERT_IMPLIES(a_ovf_at_capacity, i_clk, i_rst_n,
                    m_axis_tvalid && result.ovf,
                    result.cnt == CNT_W'(MAX_POINTS))

endmodule

`default_nettype wire

[src/smrs_front.sv]
// Front end: accepts sample beats and accumulates sum, sum of squares and count.
// Depends on smrs_pkg; pushes closed runs into smrs_queue.
`default_nettype none

module smrs_front
    import smrs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_has_sample,
    input  wire logic                i_last,
    input  wire logic [LVL_W-1:0]    i_level,
    output logic                     o_push,
    output t_job                     o_job
);

    logic                    accept;
    logic                    take;
    logic [SAMPLE_W-1:0]     mag;
    logic [CNT_W-1:0]        n_cnt;
    logic                    n_ovf;
    logic signed [SUM_W-1:0] n_sum;
    logic [SQ_W-1:0]         n_sq;

    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;

    logic                    r_s1_vld;
    logic                    r_s1_take;
    logic                    r_s1_last;
    logic [SAMPLE_W-1:0]     r_s1_val;
    logic [PROD_W-1:0]       r_s1_prod;
    logic [CNT_W-1:0]        r_s1_cnt;
    logic                    r_s1_ovf;

    // room is kept for a close-out still in the square stage
    assign o_ready = ({1'b0, i_level} + (LVL_W+1)'(r_s1_vld & r_s1_last))
                     < (LVL_W+1)'(Q_DEPTH);
    assign accept  = i_valid & o_ready;

    // count and capacity check at the accept stage
    assign take  = i_has_sample & (r_cnt < CNT_W'(MAX_POINTS));
    assign n_cnt = r_cnt + CNT_W'(take);
    assign n_ovf = r_ovf | (i_has_sample & ~take);
    assign mag   = i_sample[SAMPLE_W-1] ? (~i_sample + SAMPLE_W'(1)) : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            if (accept) begin
                if (i_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_cnt <= n_cnt;
                    r_ovf <= n_ovf;
                end
            end
        end
    end

    // square stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_take <= take;
            r_s1_last <= i_last;
            r_s1_val  <= i_sample;
            r_s1_prod <= PROD_W'(mag) * PROD_W'(mag);
            r_s1_cnt  <= n_cnt;
            r_s1_ovf  <= n_ovf;
        end
    end

    // accumulate sum and sum of squares in the cycle after the accept
    assign n_sum = r_sum + (r_s1_take
                   ? {{(SUM_W-SAMPLE_W){r_s1_val[SAMPLE_W-1]}}, r_s1_val}
                   : SUM_W'(0));
    assign n_sq  = r_sq + (r_s1_take ? SQ_W'(r_s1_prod) : SQ_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
        end else if (r_s1_vld) begin
            if (r_s1_last) begin
                r_sum <= '0;
                r_sq  <= '0;
            end else begin
                r_sum <= n_sum;
                r_sq  <= n_sq;
            end
        end
    end

    assign o_push    = r_s1_vld & r_s1_last;
    assign o_job.sum = n_sum;
    assign o_job.sq  = n_sq;
    assign o_job.cnt = r_s1_cnt;
    assign o_job.ovf = r_s1_ovf;

endmodule

`default_nettype wire

[src/smrs_queue.sv]
// Short queue of closed runs between the accumulator and the back end.
// Depends on smrs_pkg.
`default_nettype none

module smrs_queue
    import smrs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_job             i_job,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output t_job                  o_job,
    output logic [LVL_W-1:0]      o_level
);

    t_job             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [LVL_W-1:0] r_level;
    logic             do_pop;

    assign do_pop  = i_pop & (r_level != '0);
    assign o_valid = (r_level != '0);
    assign o_job   = r_mem[r_rptr];
    assign o_level = r_level;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_AW'(1);
            end
            r_level <= r_level + LVL_W'(i_push) - LVL_W'(do_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[src/smrs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by mean and mean square.
// Depends on smrs_pkg.
`default_nettype none

module smrs_div
    import smrs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_dq;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    // one trial subtract per step
    assign rem_sh = {r_rem, r_dq[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_dq   <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_dq   <= {r_dq[DIV_W-2:0], ge};
            r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_den}) : rem_sh[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

`default_nettype wire

[src/smrs_sqrt.sv]
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// Depends on smrs_pkg.
`default_nettype none

module smrs_sqrt
    import smrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SQRT_IN_W-1:0] i_radicand,
    output logic                      o_done,
    output logic [ROOT_W:0]           o_root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [SQRT_IN_W-1:0] r_m;
    logic [ROOT_W-1:0]    r_root;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 ge;

    // bring down two bits, try root*4+1
    assign rem_sh = {r_rem[REM_W-3:0], r_m[SQRT_IN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_m    <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_m    <= {r_m[SQRT_IN_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    // remainder is m - root^2; round up when it exceeds root
    assign o_done = r_done;
    assign o_root = {1'b0, r_root}
                    + (ROOT_W+1)'(r_rem > {{(REM_W-ROOT_W){1'b0}}, r_root});

endmodule

`default_nettype wire

[src/smrs_back.sv]
// Back end: sequences divide, square root and multiply steps for one closed run.
// Depends on smrs_pkg, smrs_div and smrs_sqrt; holds the result output register.
`default_nettype none

module smrs_back
    import smrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_result   o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MEAN,
        S_DIV_SQ,
        S_SQRT_RMS,
        S_MUL,
        S_SUB,
        S_SQRT_SD,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ovf;
    logic                 r_mean_neg;
    logic [SAMPLE_W-1:0]  r_mean_mag;
    logic [SAMPLE_W-1:0]  r_rms;
    logic [SAMPLE_W-1:0]  r_sd;
    logic [PROD_W-1:0]    r_rms_sq;
    logic [PROD_W-1:0]    r_mean_sq;
    logic                 r_div_start;
    logic [DIV_W-1:0]     r_div_a;
    logic                 r_sqrt_start;
    logic [SQRT_IN_W-1:0] r_sqrt_a;
    logic                 r_out_vld;
    t_result              r_out;

    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;
    logic                 sqrt_done;
    logic [ROOT_W:0]      sqrt_root;
    logic [SUM_W-1:0]     sum_mag;
    logic [PROD_W-1:0]    rad;
    logic                 out_free;

    smrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    smrs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (r_sqrt_a),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // magnitude of the run sum, and radicand for the deviation
    assign sum_mag  = i_job.sum[SUM_W-1] ? SUM_W'(-i_job.sum) : SUM_W'(i_job.sum);
    assign rad      = (r_rms_sq > r_mean_sq) ? (r_rms_sq - r_mean_sq) : '0;
    assign out_free = ~r_out_vld | i_ready;
    assign o_pop    = (r_state == S_IDLE) & i_q_valid;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            // S_OUT reloads the register itself when the beat leaves
            if (r_out_vld && i_ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cnt      <= i_job.cnt;
                        r_ovf      <= i_job.ovf;
                        r_div_a    <= DIV_W'(sum_mag + SUM_W'(i_job.cnt >> 1));
                        r_mean_neg <= i_job.sum[SUM_W-1];
                        if (i_job.cnt == '0) begin
                            r_mean_mag <= '0;
                            r_rms      <= '0;
                            r_sd       <= '0;
                            r_state    <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_MEAN;
                        end
                        if (i_job.cnt != '0) begin
                            r_sqrt_a <= SQRT_IN_W'(i_job.sq);
                        end
                    end
                end
                S_DIV_MEAN: begin
                    if (div_done) begin
                        r_mean_mag  <= div_quot[SAMPLE_W-1:0];
                        r_div_a     <= DIV_W'(r_sqrt_a);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_SQ;
                    end
                end
                S_DIV_SQ: begin
                    if (div_done) begin
                        r_sqrt_a     <= SQRT_IN_W'(div_quot);
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_SQRT_RMS;
                    end
                end
                S_SQRT_RMS: begin
                    if (sqrt_done) begin
                        r_rms   <= sqrt_root[SAMPLE_W-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rms_sq  <= PROD_W'(r_rms) * PROD_W'(r_rms);
                    r_mean_sq <= PROD_W'(r_mean_mag) * PROD_W'(r_mean_mag);
                    r_state   <= S_SUB;
                end
                S_SUB: begin
                    r_sqrt_a     <= SQRT_IN_W'(rad);
                    r_sqrt_start <= 1'b1;
                    r_state      <= S_SQRT_SD;
                end
                S_SQRT_SD: begin
                    if (sqrt_done) begin
                        r_sd    <= sqrt_root[SAMPLE_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.mean  <= r_mean_neg ? (~r_mean_mag + SAMPLE_W'(1))
                                                  : r_mean_mag;
                        r_out.rms   <= r_rms;
                        r_out.stdev <= r_sd;
                        r_out.cnt   <= r_cnt;
                        r_out.ovf   <= r_ovf;
                        r_out_vld   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire
